/* hdl/gbs_pkg.sv */
// Shared types and constants for the GGX BRDF shader.
`timescale 1ns / 1ps
`default_nettype none
package gbs_pkg;

  // One fragment: normal, view and light vectors, signed Q1.14.
  typedef struct packed {
    logic signed [15:0] n_x;
    logic signed [15:0] n_y;
    logic signed [15:0] n_z;
    logic signed [15:0] v_x;
    logic signed [15:0] v_y;
    logic signed [15:0] v_z;
    logic signed [15:0] l_x;
    logic signed [15:0] l_y;
    logic signed [15:0] l_z;
  } frag_t;

  // One shaded result, unsigned Q8.16 per channel.
  typedef struct packed {
    logic [23:0] out_red;
    logic [23:0] out_green;
    logic [23:0] out_blue;
  } shade_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_ROUGHNESS = 1'b0,
    REG_F0        = 1'b1
  } cfg_reg_t;

  localparam logic [15:0] ROUGHNESS_RST = 16'hFFFF;
  localparam logic [15:0] F0_RST        = 16'd6554;
  localparam logic [16:0] ONE_Q16       = 17'h1_0000;
  localparam logic [32:0] ONE_Q32       = 33'h1_0000_0000;
  localparam logic [14:0] INV_PI_Q16    = 15'd20861;
  localparam logic [39:0] SAT_CAP       = 40'hFF_FFFF_FFFF;
  localparam logic [23:0] OUT_MAX       = 24'hFF_FFFF;
  localparam logic [34:0] VIS_SAT_LIM   = 35'd128;

endpackage
`default_nettype wire

/* hdl/gbs_stream_if.sv */
// Valid/ready stream channel carrying one item of type T.
`timescale 1ns / 1ps
`default_nettype none
interface gbs_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/gbs_sqrt_pipe.sv */
// Pipelined integer square root, one result bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none
module gbs_sqrt_pipe #(
  parameter int XW = 34,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [XW-1:0] x,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [XW/2-1:0]    root,
  output logic [SW-1:0]      out_side
);
  localparam int RW = XW / 2;

  logic [XW-1:0] xs   [RW];
  logic [RW:0]   rem  [RW];
  logic [RW-1:0] rt   [RW+1];
  logic          vld  [RW+1];
  logic [SW-1:0] sd   [RW+1];

  assign xs[0]  = x;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign vld[0] = in_valid;
  assign sd[0]  = in_side;

  for (genvar i = 1; i <= RW; i++) begin : g_stage
    logic [RW+1:0] rn;
    logic [RW+1:0] trial;
    logic          ge;

    assign rn    = {rem[i-1][RW-1:0], xs[i-1][XW-1:XW-2]};
    assign trial = {rt[i-1], 2'b01};
    assign ge    = rn >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt[i] <= {rt[i-1][RW-2:0], ge};
        sd[i] <= sd[i-1];
      end
    end

    if (i < RW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= ge ? (RW+1)'(rn - trial) : (RW+1)'(rn);
          xs[i]  <= xs[i-1] << 2;
        end
      end
    end
  end

  assign out_valid = vld[RW];
  assign root      = rt[RW];
  assign out_side  = sd[RW];
endmodule
`default_nettype wire

/* hdl/gbs_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// The caller keeps num below den shifted left by QW.
`timescale 1ns / 1ps
`default_nettype none
module gbs_div_pipe #(
  parameter int DW = 25,
  parameter int QW = 17,
  parameter int SW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [DW+QW-1:0] num,
  input  wire logic [DW-1:0]    den,
  input  wire logic [SW-1:0]    in_side,
  output logic                  out_valid,
  output logic [QW-1:0]         quot,
  output logic [SW-1:0]         out_side
);
  localparam int RMW = DW + QW;

  logic [RMW-1:0] rem [QW];
  logic [DW-1:0]  dv  [QW];
  logic [QW-1:0]  quo [QW+1];
  logic           vld [QW+1];
  logic [SW-1:0]  sd  [QW+1];

  assign rem[0] = num;
  assign dv[0]  = den;
  assign quo[0] = '0;
  assign vld[0] = in_valid;
  assign sd[0]  = in_side;

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    localparam int B = QW - i;
    logic [RMW-1:0] sh;
    logic           ge;

    assign sh = RMW'(dv[i-1]) << B;
    assign ge = rem[i-1] >= sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[i] <= {quo[i-1][QW-2:0], ge};
        sd[i]  <= sd[i-1];
      end
    end

    if (i < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= ge ? rem[i-1] - sh : rem[i-1];
          dv[i]  <= dv[i-1];
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign quot      = quo[QW];
  assign out_side  = sd[QW];
endmodule
`default_nettype wire

/* hdl/ggx_brdf_shader.sv */
// GGX specular plus red Lambert diffuse shader, one fragment per unstalled clock.
//
// frag (sink): one item per fragment, normal N, view V and light L as
//   signed Q1.14 components. shade (source): one item per fragment, RGB in
//   unsigned Q8.16, saturated at all ones, in fragment order.
// cfg_we/cfg_index/cfg_data: register write port. Index REG_ROUGHNESS sets
//   the perceptual roughness (Q0.16), REG_F0 the Fresnel F0 (Q0.16). Write
//   only while no fragment is in flight.
// Throughput: one item per cycle while frag.ready is high. The depth is set
//   by the four bit-serial pipes: the half-vector length root (25 stages),
//   the NoH/LoH divide (17), the Smith roots (17) and the GGX / visibility
//   divides (40), plus 16 math stages.
// The whole pipe moves on one enable. A two-entry output skid sits behind
//   it; frag.ready drops only when both entries hold results, so an item is
//   still taken while one result waits. A stall freezes every stage, so no
//   item is lost or repeated.
// Reset (rst, synchronous): clears all valid bits and the skid, and sets
//   roughness to 65535 and F0 to 6554. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module ggx_brdf_shader
  import gbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  gbs_stream_if.sink       frag,
  gbs_stream_if.source     shade,
  input  wire logic        cfg_we,
  input  wire cfg_reg_t    cfg_index,
  input  wire logic [15:0] cfg_data
);

  // ---------------------------------------------------------------- config
  logic [15:0] pr_cfg;
  logic [15:0] f0_cfg;
  logic [15:0] r_cfg;    // roughness, Q.16
  logic [31:0] a2_cfg;   // roughness squared, Q.32
  logic [31:0] pr_sq;
  logic [31:0] r_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_cfg <= ROUGHNESS_RST;
      f0_cfg <= F0_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROUGHNESS: pr_cfg <= cfg_data;
        REG_F0:        f0_cfg <= cfg_data;
        default:       ;
      endcase
    end
  end

  // r_cfg is registered from pr_cfg, then a2_cfg from r_cfg, long before use.
  assign pr_sq = pr_cfg * pr_cfg;
  assign r_sq  = r_cfg * r_cfg;
  always_ff @(posedge clk) begin
    r_cfg  <= pr_sq[31:16];
    a2_cfg <= r_sq;
  end

  // ---------------------------------------------------------- flow control
  logic [1:0] cnt;
  logic       adv;

  assign adv        = cnt != 2'd2;
  assign frag.ready = adv;

  // -------------------------------------------- stage a: input, S = V + L
  logic               va;
  logic signed [15:0] a_n [3];
  logic signed [15:0] a_v [3];
  logic signed [15:0] a_l [3];
  logic signed [16:0] a_s [3];
  logic signed [15:0] in_n [3];
  logic signed [15:0] in_v [3];
  logic signed [15:0] in_l [3];

  assign in_n[0] = frag.data.n_x;
  assign in_n[1] = frag.data.n_y;
  assign in_n[2] = frag.data.n_z;
  assign in_v[0] = frag.data.v_x;
  assign in_v[1] = frag.data.v_y;
  assign in_v[2] = frag.data.v_z;
  assign in_l[0] = frag.data.l_x;
  assign in_l[1] = frag.data.l_y;
  assign in_l[2] = frag.data.l_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_n[i] <= in_n[i];
        a_v[i] <= in_v[i];
        a_l[i] <= in_l[i];
        a_s[i] <= 17'(in_v[i]) + 17'(in_l[i]);
      end
    end
  end

  // -------------------------------------------- stage b: component products
  logic               vb;
  logic signed [31:0] b_nv [3];
  logic signed [31:0] b_nl [3];
  logic signed [32:0] b_ns [3];
  logic signed [32:0] b_ls [3];
  logic signed [33:0] b_ss [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_nv[i] <= a_n[i] * a_v[i];
        b_nl[i] <= a_n[i] * a_l[i];
        b_ns[i] <= a_n[i] * a_s[i];
        b_ls[i] <= a_l[i] * a_s[i];
        b_ss[i] <= a_s[i] * a_s[i];
      end
    end
  end

  // ------------------------------------------------ stage c: dot products
  logic               vc;
  logic signed [33:0] c_nv;
  logic signed [33:0] c_nl;
  logic signed [34:0] c_ns;
  logic signed [34:0] c_ls;
  logic [33:0]        c_len2;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_nv   <= 34'(b_nv[0]) + 34'(b_nv[1]) + 34'(b_nv[2]);
      c_nl   <= 34'(b_nl[0]) + 34'(b_nl[1]) + 34'(b_nl[2]);
      c_ns   <= 35'(b_ns[0]) + 35'(b_ns[1]) + 35'(b_ns[2]);
      c_ls   <= 35'(b_ls[0]) + 35'(b_ls[1]) + 35'(b_ls[2]);
      c_len2 <= b_ss[0][33:0] + b_ss[1][33:0] + b_ss[2][33:0];
    end
  end

  // ------------------------- cosines, then |S| root with dividends alongside
  typedef struct packed {
    logic [16:0] no_v;
    logic [16:0] no_l;
    logic [19:0] scale;
    logic [43:0] ns_div;
    logic [43:0] ls_div;
    logic        ns_pos;
    logic        ls_pos;
  } hs_side_t;

  hs_side_t    hs_in;
  hs_side_t    hs_out;
  logic [33:0] abs_nv;
  logic [22:0] nv_q;
  logic [19:0] scale_c;
  logic [24:0] q_len;
  logic        hs_vld;

  assign abs_nv  = c_nv[33] ? 34'(-c_nv) : 34'(c_nv);
  assign nv_q    = 23'(abs_nv[33:12]) + 23'd1;
  assign scale_c = (!c_nl[33] && c_nl != '0) ? c_nl[31:12] : '0;

  always_comb begin
    hs_in.no_v   = (nv_q > 23'(ONE_Q16)) ? ONE_Q16 : nv_q[16:0];
    hs_in.scale  = scale_c;
    hs_in.no_l   = (scale_c > 20'(ONE_Q16)) ? ONE_Q16 : scale_c[16:0];
    hs_in.ns_pos = !c_ns[34] && c_ns != '0;
    hs_in.ls_pos = !c_ls[34] && c_ls != '0;
    hs_in.ns_div = hs_in.ns_pos ? {c_ns[33:0], 10'b0} : '0;
    hs_in.ls_div = hs_in.ls_pos ? {c_ls[33:0], 10'b0} : '0;
  end

  gbs_sqrt_pipe #(.XW(50), .SW($bits(hs_side_t))) u_len_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (vc),
    .x        ({c_len2, 16'b0}),
    .in_side  (hs_in),
    .out_valid(hs_vld),
    .root     (q_len),
    .out_side (hs_out)
  );

  // --------------------------------------------------- NoH and LoH divides
  typedef struct packed {
    logic [16:0] no_v;
    logic [16:0] no_l;
    logic [19:0] scale;
    logic        zero;
    logic        sat;
  } dh_side_t;

  typedef struct packed {
    logic zero;
    logic sat;
  } dl_side_t;

  dh_side_t    dh_in;
  dh_side_t    dh_out;
  dl_side_t    dl_in;
  dl_side_t    dl_out;
  logic [43:0] q_sh;
  logic [41:0] num_h;
  logic [41:0] num_l;
  logic [16:0] qh;
  logic [16:0] ql;
  logic        dh_vld;
  logic        dl_vld;

  assign q_sh = 44'({q_len, 17'b0});

  always_comb begin
    dh_in.no_v  = hs_out.no_v;
    dh_in.no_l  = hs_out.no_l;
    dh_in.scale = hs_out.scale;
    dh_in.zero  = q_len == '0 || !hs_out.ns_pos;
    dh_in.sat   = !dh_in.zero && hs_out.ns_div >= q_sh;
    dl_in.zero  = q_len == '0 || !hs_out.ls_pos;
    dl_in.sat   = !dl_in.zero && hs_out.ls_div >= q_sh;
    num_h       = (dh_in.zero || dh_in.sat) ? '0 : hs_out.ns_div[41:0];
    num_l       = (dl_in.zero || dl_in.sat) ? '0 : hs_out.ls_div[41:0];
  end

  gbs_div_pipe #(.DW(25), .QW(17), .SW($bits(dh_side_t))) u_noh_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (hs_vld),
    .num      (num_h),
    .den      (q_len),
    .in_side  (dh_in),
    .out_valid(dh_vld),
    .quot     (qh),
    .out_side (dh_out)
  );

  gbs_div_pipe #(.DW(25), .QW(17), .SW($bits(dl_side_t))) u_loh_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (hs_vld),
    .num      (num_l),
    .den      (q_len),
    .in_side  (dl_in),
    .out_valid(dl_vld),
    .quot     (ql),
    .out_side (dl_out)
  );

  // ------------------------------------------- stage e: clamp NoH and LoH
  logic        ve;
  logic [16:0] e_no_h;
  logic [16:0] e_lo_h;
  logic [16:0] e_no_v;
  logic [16:0] e_no_l;
  logic [19:0] e_scale;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_no_h  <= dh_out.zero ? '0 : (dh_out.sat || qh > ONE_Q16) ? ONE_Q16 : qh;
      e_lo_h  <= dl_out.zero ? '0 : (dl_out.sat || ql > ONE_Q16) ? ONE_Q16 : ql;
      e_no_v  <= dh_out.no_v;
      e_no_l  <= dh_out.no_l;
      e_scale <= dh_out.scale;
    end
  end

  // ---------------------- stages g1..g3: GGX denominator, Smith, Fresnel
  logic        vg1;
  logic [32:0] g1_h2;
  logic [31:0] g1_t;
  logic [32:0] g1_x2v;
  logic [32:0] g1_x2l;
  logic [16:0] g1_w;
  logic [16:0] g1_ww;
  logic [16:0] g1_no_v;
  logic [16:0] g1_no_l;
  logic [19:0] g1_scale;
  logic [16:0] w_e;
  logic [33:0] h2_p;
  logic [32:0] t_p;
  logic [33:0] x2v_p;
  logic [33:0] x2l_p;
  logic [33:0] ww_p;

  assign w_e   = ONE_Q16 - e_lo_h;
  assign h2_p  = e_no_h * e_no_h;
  assign t_p   = e_no_h * r_cfg;
  assign x2v_p = e_no_v * e_no_v;
  assign x2l_p = e_no_l * e_no_l;
  assign ww_p  = w_e * w_e;

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_h2    <= h2_p[32:0];
      g1_t     <= t_p[31:0];
      g1_x2v   <= x2v_p[32:0];
      g1_x2l   <= x2l_p[32:0];
      g1_w     <= w_e;
      g1_ww    <= ww_p[32:16];
      g1_no_v  <= e_no_v;
      g1_no_l  <= e_no_l;
      g1_scale <= e_scale;
    end
  end

  logic        vg2;
  logic [32:0] g2_h2;
  logic [31:0] g2_tt;
  logic [32:0] g2_x2v;
  logic [32:0] g2_x2l;
  logic [31:0] g2_mv;
  logic [31:0] g2_ml;
  logic [16:0] g2_w;
  logic [16:0] g2_w4;
  logic [16:0] g2_no_v;
  logic [16:0] g2_no_l;
  logic [19:0] g2_scale;
  logic [63:0] tt_p;
  logic [64:0] mv_p;
  logic [64:0] ml_p;
  logic [33:0] w4_p;

  assign tt_p = g1_t * g1_t;
  assign mv_p = g1_x2v * a2_cfg;
  assign ml_p = g1_x2l * a2_cfg;
  assign w4_p = g1_ww * g1_ww;

  always_ff @(posedge clk) begin
    if (adv) begin
      g2_h2    <= g1_h2;
      g2_tt    <= tt_p[63:32];
      g2_x2v   <= g1_x2v;
      g2_x2l   <= g1_x2l;
      g2_mv    <= mv_p[63:32];
      g2_ml    <= ml_p[63:32];
      g2_w     <= g1_w;
      g2_w4    <= w4_p[32:16];
      g2_no_v  <= g1_no_v;
      g2_no_l  <= g1_no_l;
      g2_scale <= g1_scale;
    end
  end

  logic        vg3;
  logic [32:0] g3_den;
  logic [33:0] g3_in_v;
  logic [33:0] g3_in_l;
  logic [16:0] g3_w5;
  logic [16:0] g3_no_v;
  logic [16:0] g3_no_l;
  logic [19:0] g3_scale;
  logic [33:0] w5_p;

  assign w5_p = g2_w4 * g2_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      g3_den   <= (ONE_Q32 - g2_h2) + 33'(g2_tt);
      g3_in_v  <= 34'(g2_x2v) - 34'(g2_mv) + 34'(a2_cfg);
      g3_in_l  <= 34'(g2_x2l) - 34'(g2_ml) + 34'(a2_cfg);
      g3_w5    <= w5_p[32:16];
      g3_no_v  <= g2_no_v;
      g3_no_l  <= g2_no_l;
      g3_scale <= g2_scale;
    end
  end

  // ------------------------------------------------------- Smith roots
  typedef struct packed {
    logic [32:0] den;
    logic [16:0] w5;
    logic [19:0] scale;
  } sv_side_t;

  typedef struct packed {
    logic [16:0] no_v;
    logic [16:0] no_l;
  } sl_side_t;

  sv_side_t    sv_out;
  sl_side_t    sl_out;
  logic [16:0] sq_v;
  logic [16:0] sq_l;
  logic        sv_vld;
  logic        sl_vld;

  gbs_sqrt_pipe #(.XW(34), .SW($bits(sv_side_t))) u_smith_v (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (vg3),
    .x        (g3_in_v),
    .in_side  ({g3_den, g3_w5, g3_scale}),
    .out_valid(sv_vld),
    .root     (sq_v),
    .out_side (sv_out)
  );

  gbs_sqrt_pipe #(.XW(34), .SW($bits(sl_side_t))) u_smith_l (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (vg3),
    .x        (g3_in_l),
    .in_side  ({g3_no_v, g3_no_l}),
    .out_valid(sl_vld),
    .root     (sq_l),
    .out_side (sl_out)
  );

  // ---------------------------- stage p: visibility sum and Fresnel term
  logic        vp;
  logic [34:0] p_sum;
  logic [32:0] p_den;
  logic [16:0] p_f;
  logic [19:0] p_scale;
  logic [33:0] sv_p;
  logic [33:0] sl_p;
  logic [16:0] f_rest;
  logic [33:0] fm_p;

  assign sv_p   = sl_out.no_l * sq_v;
  assign sl_p   = sl_out.no_v * sq_l;
  assign f_rest = ONE_Q16 - 17'(f0_cfg);
  assign fm_p   = f_rest * sv_out.w5;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_sum   <= 35'(sv_p) + 35'(sl_p);
      p_den   <= sv_out.den;
      p_f     <= 17'(f0_cfg) + fm_p[32:16];
      p_scale <= sv_out.scale;
    end
  end

  // ------------------------------------------ GGX k and visibility divides
  typedef struct packed {
    logic        sat;
    logic [16:0] f;
    logic [19:0] scale;
  } dk_side_t;

  dk_side_t    dk_in;
  dk_side_t    dk_out;
  logic [72:0] num_k;
  logic [74:0] num_vis;
  logic [39:0] kq;
  logic [39:0] vq;
  logic        vis_sat;
  logic        vis_sat_out;
  logic        dk_vld;
  logic        dvis_vld;

  // k = (r << 32) / den saturates when den is zero or the quotient passes 40 bits
  always_comb begin
    dk_in.sat   = p_den == '0 || 73'({r_cfg, 32'b0}) >= {p_den, 40'b0};
    dk_in.f     = p_f;
    dk_in.scale = p_scale;
    num_k       = dk_in.sat ? '0 : 73'({r_cfg, 32'b0});
    vis_sat     = p_sum <= VIS_SAT_LIM;
    num_vis     = vis_sat ? '0 : (75'd1 << 47);
  end

  gbs_div_pipe #(.DW(33), .QW(40), .SW($bits(dk_side_t))) u_k_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (vp),
    .num      (num_k),
    .den      (p_den),
    .in_side  (dk_in),
    .out_valid(dk_vld),
    .quot     (kq),
    .out_side (dk_out)
  );

  gbs_div_pipe #(.DW(35), .QW(40), .SW(1)) u_vis_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (vp),
    .num      (num_vis),
    .den      (p_sum),
    .in_side  (vis_sat),
    .out_valid(dvis_vld),
    .quot     (vq),
    .out_side (vis_sat_out)
  );

  // ---------------------------------------- stages e1..e8: product chain
  logic        ve1;
  logic [39:0] e1_k;
  logic [39:0] e1_vis;
  logic [16:0] e1_f;
  logic [19:0] e1_scale;

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_k     <= dk_out.sat ? SAT_CAP : kq;
      e1_vis   <= vis_sat_out ? SAT_CAP : vq;
      e1_f     <= dk_out.f;
      e1_scale <= dk_out.scale;
    end
  end

  // k*k >> 16 passes the cap exactly when k reaches 2^28
  logic        ve2;
  logic [39:0] e2_kk;
  logic [39:0] e2_vis;
  logic [16:0] e2_f;
  logic [19:0] e2_scale;
  logic [55:0] kk_p;

  assign kk_p = e1_k[27:0] * e1_k[27:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_kk    <= (e1_k[39:28] != '0) ? SAT_CAP : kk_p[55:16];
      e2_vis   <= e1_vis;
      e2_f     <= e1_f;
      e2_scale <= e1_scale;
    end
  end

  logic        ve3;
  logic [38:0] e3_d;
  logic [39:0] e3_vis;
  logic [16:0] e3_f;
  logic [19:0] e3_scale;
  logic [54:0] d_p;

  assign d_p = e2_kk * INV_PI_Q16;

  always_ff @(posedge clk) begin
    if (adv) begin
      e3_d     <= d_p[54:16];
      e3_vis   <= e2_vis;
      e3_f     <= e2_f;
      e3_scale <= e2_scale;
    end
  end

  // D * Vis in four partial products of 20-bit and 19-bit halves
  logic        ve4;
  logic [39:0] e4_ll;
  logic [39:0] e4_lh;
  logic [38:0] e4_hl;
  logic [38:0] e4_hh;
  logic [16:0] e4_f;
  logic [19:0] e4_scale;
  logic [39:0] ll_p;
  logic [39:0] lh_p;
  logic [38:0] hl_p;
  logic [38:0] hh_p;

  assign ll_p = e3_d[19:0] * e3_vis[19:0];
  assign lh_p = e3_d[19:0] * e3_vis[39:20];
  assign hl_p = e3_d[38:20] * e3_vis[19:0];
  assign hh_p = e3_d[38:20] * e3_vis[39:20];

  always_ff @(posedge clk) begin
    if (adv) begin
      e4_ll    <= ll_p;
      e4_lh    <= lh_p;
      e4_hl    <= hl_p;
      e4_hh    <= hh_p;
      e4_f     <= e3_f;
      e4_scale <= e3_scale;
    end
  end

  logic        ve5;
  logic [79:0] e5_dv;
  logic [16:0] e5_f;
  logic [19:0] e5_scale;

  always_ff @(posedge clk) begin
    if (adv) begin
      e5_dv    <= 80'(e4_ll) + (80'(e4_lh) << 20) + (80'(e4_hl) << 20)
                + (80'(e4_hh) << 40);
      e5_f     <= e4_f;
      e5_scale <= e4_scale;
    end
  end

  logic        ve6;
  logic [39:0] e6_dv;
  logic [16:0] e6_f;
  logic [19:0] e6_scale;

  always_ff @(posedge clk) begin
    if (adv) begin
      e6_dv    <= (e5_dv[79:56] != '0) ? SAT_CAP : e5_dv[55:16];
      e6_f     <= e5_f;
      e6_scale <= e5_scale;
    end
  end

  logic        ve7;
  logic [39:0] e7_spec;
  logic [19:0] e7_scale;
  logic [56:0] sf_p;

  assign sf_p = e6_dv * e6_f;

  always_ff @(posedge clk) begin
    if (adv) begin
      e7_spec  <= sf_p[56] ? SAT_CAP : sf_p[55:16];
      e7_scale <= e6_scale;
    end
  end

  // red carries the Lambert term; the 40-bit cap is above the output cap
  logic        ve8;
  shade_t      e8_res;
  logic [60:0] red_p;
  logic [59:0] grn_p;

  assign red_p = (41'(e7_spec) + 41'(INV_PI_Q16)) * e7_scale;
  assign grn_p = e7_spec * e7_scale;

  always_ff @(posedge clk) begin
    if (adv) begin
      e8_res.out_red   <= (red_p[60:40] != '0) ? OUT_MAX : red_p[39:16];
      e8_res.out_green <= (grn_p[59:40] != '0) ? OUT_MAX : grn_p[39:16];
      e8_res.out_blue  <= (grn_p[59:40] != '0) ? OUT_MAX : grn_p[39:16];
    end
  end

  // ------------------------------------------------------ valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      va  <= 1'b0;
      vb  <= 1'b0;
      vc  <= 1'b0;
      ve  <= 1'b0;
      vg1 <= 1'b0;
      vg2 <= 1'b0;
      vg3 <= 1'b0;
      vp  <= 1'b0;
      ve1 <= 1'b0;
      ve2 <= 1'b0;
      ve3 <= 1'b0;
      ve4 <= 1'b0;
      ve5 <= 1'b0;
      ve6 <= 1'b0;
      ve7 <= 1'b0;
      ve8 <= 1'b0;
    end else if (adv) begin
      va  <= frag.valid;
      vb  <= va;
      vc  <= vb;
      ve  <= dh_vld && dl_vld;
      vg1 <= ve;
      vg2 <= vg1;
      vg3 <= vg2;
      vp  <= sv_vld && sl_vld;
      ve1 <= dk_vld && dvis_vld;
      ve2 <= ve1;
      ve3 <= ve2;
      ve4 <= ve3;
      ve5 <= ve4;
      ve6 <= ve5;
      ve7 <= ve6;
      ve8 <= ve7;
    end
  end

  // ------------------------------------------------- two-entry output skid
  shade_t q0;
  shade_t q1;
  logic   push;
  logic   pop;

  assign push        = adv && ve8;
  assign pop         = shade.valid && shade.ready;
  assign shade.valid = cnt != 2'd0;
  assign shade.data  = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) begin
          q0 <= e8_res;
        end else begin
          q1 <= e8_res;
        end
      end
      2'b01: begin
        q0 <= q1;
      end
      2'b11: begin
        q0 <= e8_res;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------ checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("output skid count out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(ve8) && $stable(vp))
    else $error("pipeline moved during a stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> cnt == 2'd0 && !ve8)
    else $error("pipeline not empty after reset");

  a_red_ge_green: assert property (@(posedge clk) disable iff (rst)
    shade.valid |-> shade.data.out_red >= shade.data.out_green
      && shade.data.out_blue == shade.data.out_green)
    else $error("red below green or blue differs from green");

endmodule
`default_nettype wire

/* sim/ggx_shade_checker.sv */
// Watches the fragment and shade channels, predicts each shaded result and compares.
`timescale 1ns / 1ps
module ggx_shade_checker
  import gbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  gbs_stream_if       frag_mon,
  gbs_stream_if       shade_mon,
  input  logic        cfg_we,
  input  cfg_reg_t    cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);
  typedef longint unsigned u64_t;

  localparam u64_t CAP  = u64_t'(SAT_CAP);
  localparam u64_t ONE  = 64'd65536;
  localparam u64_t IPI  = 64'd20861;

  logic [15:0] rough_q;
  logic [15:0] f0_q;
  shade_t      shade_exp_q[$];

  function automatic u64_t root64(u64_t x);
    u64_t res = 0;
    u64_t b   = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // product shifted to Q.16, capped at 40 bits
  function automatic u64_t mul_cap(u64_t a, u64_t b);
    u64_t p;
    if (a == 0 || b == 0) return 0;
    if (a > 64'hFFFF_FFFF_FFFF_FFFF / b) return CAP;
    p = (a * b) >> 16;
    return (p > CAP) ? CAP : p;
  endfunction

  function automatic u64_t clamp_one(u64_t x);
    return (x > ONE) ? ONE : x;
  endfunction

  function automatic u64_t half_angle_cos(longint dot, u64_t q);
    if (q == 0 || dot <= 0) return 0;
    return clamp_one((u64_t'(dot) * 1024) / q);
  endfunction

  function automatic u64_t smith_root(u64_t x, u64_t a2);
    u64_t x2 = x * x;
    return root64(x2 - ((x2 * a2) >> 32) + a2);
  endfunction

  function automatic shade_t shade_of(frag_t fr, logic [15:0] pr, logic [15:0] f0);
    longint n[3], v[3], l[3], s[3];
    longint nv, nl, ns, ls;
    u64_t len2, q, no_v, no_l, no_h, lo_h, scale;
    u64_t r, a2, t, den, k, d, sum, vis, w, w5, f, spec, red, grn;
    shade_t o;
    n = '{fr.n_x, fr.n_y, fr.n_z};
    v = '{fr.v_x, fr.v_y, fr.v_z};
    l = '{fr.l_x, fr.l_y, fr.l_z};
    nv = 0; nl = 0; ns = 0; ls = 0; len2 = 0;
    for (int i = 0; i < 3; i++) s[i] = v[i] + l[i];
    for (int i = 0; i < 3; i++) begin
      nv += n[i] * v[i];
      nl += n[i] * l[i];
      ns += n[i] * s[i];
      ls += l[i] * s[i];
      len2 += u64_t'(s[i] * s[i]);
    end
    no_v  = clamp_one((u64_t'(nv < 0 ? -nv : nv) >> 12) + 1);
    scale = (nl > 0) ? (u64_t'(nl) >> 12) : 0;
    no_l  = clamp_one(scale);
    q     = root64(len2 << 16);
    no_h  = half_angle_cos(ns, q);
    lo_h  = half_angle_cos(ls, q);

    r  = (u64_t'(pr) * u64_t'(pr)) >> 16;
    a2 = r * r;

    // GGX distribution; zero denominator saturates
    t   = no_h * r;
    den = (64'h1_0000_0000 - no_h * no_h) + ((t * t) >> 32);
    if (den == 0) k = CAP;
    else begin
      k = (r << 32) / den;
      if (k > CAP) k = CAP;
    end
    d = mul_cap(mul_cap(k, k), IPI);

    // Smith visibility; zero sum saturates
    sum = no_l * smith_root(no_v, a2) + no_v * smith_root(no_l, a2);
    if (sum == 0) vis = CAP;
    else begin
      vis = (64'd1 << 47) / sum;
      if (vis > CAP) vis = CAP;
    end

    // Schlick Fresnel
    w  = ONE - lo_h;
    w5 = (w * w) >> 16;
    w5 = (w5 * w5) >> 16;
    w5 = (w5 * w) >> 16;
    f  = u64_t'(f0) + (((ONE - u64_t'(f0)) * w5) >> 16);

    spec = mul_cap(mul_cap(d, vis), f);
    red  = mul_cap(spec + IPI, scale);
    grn  = mul_cap(spec, scale);
    o.out_red   = (red > 64'hFF_FFFF) ? OUT_MAX : red[23:0];
    o.out_green = (grn > 64'hFF_FFFF) ? OUT_MAX : grn[23:0];
    o.out_blue  = o.out_green;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("%0t: shade mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  initial pending = 0;

  always @(posedge clk) begin
    shade_t got, want;
    if (rst) begin
      rough_q = ROUGHNESS_RST;
      f0_q    = F0_RST;
      shade_exp_q.delete();
      errors  = 0;
    end else begin
      if (frag_mon.valid && frag_mon.ready)
        shade_exp_q.push_back(shade_of(frag_mon.data, rough_q, f0_q));
      if (shade_mon.valid && shade_mon.ready) begin
        got = shade_mon.data;
        if (shade_exp_q.size() == 0) begin
          $display("%0t: shade item with no fragment waiting", $time);
          errors++;
        end else begin
          want = shade_exp_q.pop_front();
          if (got.out_red !== want.out_red)
            report_mismatch("out_red", got.out_red, want.out_red);
          if (got.out_green !== want.out_green)
            report_mismatch("out_green", got.out_green, want.out_green);
          if (got.out_blue !== want.out_blue)
            report_mismatch("out_blue", got.out_blue, want.out_blue);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ROUGHNESS: rough_q = cfg_data;
          REG_F0:        f0_q    = cfg_data;
          default: ;
        endcase
      end
    end
    pending = shade_exp_q.size();
  end
endmodule

/* sim/tb_ggx_brdf_shader.sv */
// Top level of the GGX BRDF shader testbench: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_ggx_brdf_shader;
  import gbs_pkg::*;

  localparam int LATENCY    = 115;
  localparam int IDLE_LIMIT = 4000;   // cycles without any accepted item
  localparam int HOLD_LEN   = 300;    // long receiver hold-off, > pipe depth

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_ROUGHNESS;
  logic [15:0] cfg_data = '0;
  int          errors;
  int          pending;

  gbs_stream_if #(.T(frag_t))  frag_ch ();
  gbs_stream_if #(.T(shade_t)) shade_ch ();

  // Per-edge handshake flags, registered so the stimulus reads them at the
  // following falling edge without racing the block.
  logic frag_took  = 1'b0;
  logic shade_took = 1'b0;

  // Sender burst state and receiver stall control.
  int burst_left = 0;
  bit gaps_on    = 1'b1;
  bit stalls_on  = 1'b1;
  bit hold_req   = 1'b0;
  int hold_cnt   = 0;
  int idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ggx_brdf_shader i_dut (
    .clk       (clk),
    .rst       (rst),
    .frag      (frag_ch.sink),
    .shade     (shade_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ggx_shade_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .frag_mon  (frag_ch),
    .shade_mon (shade_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    frag_ch.valid  = 1'b0;
    frag_ch.data   = '0;
    shade_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    frag_took  <= frag_ch.valid && frag_ch.ready;
    shade_took <= shade_ch.valid && shade_ch.ready;
  end

  // Receiver: a long hold-off on request, else a random stall pattern.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      shade_ch.ready = 1'b0;
      hold_cnt--;
    end else if (hold_req) begin
      shade_ch.ready = 1'b0;
      hold_cnt = HOLD_LEN;
      hold_req = 1'b0;
    end else if (!stalls_on) begin
      shade_ch.ready = 1'b1;
    end else begin
      shade_ch.ready = ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || frag_took || shade_took) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one fragment; returns once it is accepted. Gaps between bursts when gaps_on is set.
  task automatic send_frag(frag_t fr);
    if (burst_left == 0) begin
      if (gaps_on) begin
        frag_ch.valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    frag_ch.valid = 1'b1;
    frag_ch.data  = fr;
    do @(negedge clk); while (!frag_took);
  endtask

  // Stop sending and let every expected result drain.
  task automatic drain;
    frag_ch.valid = 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [15:0] rand_comp();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [15:0] near_unit(bit neg);
    logic [15:0] c = 16'($urandom_range(12000, 16384));
    return neg ? -c : c;
  endfunction

  // Random fragment: mostly lit geometry (N, V, L roughly along +z with
  // random tilt), some fully random vectors, some with L along -z, some opposed
  // V/L, a little out-of-range noise on all 16 bits.
  function automatic frag_t rand_frag();
    frag_t fr;
    int    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      fr = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
    end else if (kind < 4) begin
      fr = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
            rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    end else begin
      fr.n_x = 16'($signed($urandom_range(0, 8000)) - 4000);
      fr.n_y = 16'($signed($urandom_range(0, 8000)) - 4000);
      fr.n_z = near_unit(0);
      fr.v_x = rand_comp();
      fr.v_y = 16'($signed($urandom_range(0, 16000)) - 8000);
      fr.v_z = near_unit(0);
      fr.l_x = rand_comp();
      fr.l_y = 16'($signed($urandom_range(0, 16000)) - 8000);
      fr.l_z = near_unit(kind == 4);
      if (kind == 5) begin  // opposed view and light: zero half vector
        fr.l_x = -fr.v_x;
        fr.l_y = -fr.v_y;
        fr.l_z = -fr.v_z;
      end
    end
    return fr;
  endfunction

  localparam logic [15:0] P = 16'sd16384;
  localparam logic [15:0] M = -16'sd16384;
  localparam logic [15:0] Z = 16'sd0;

  // Directed fragments: field extremes, head-on, grazing, opposed V/L,
  // back-facing light, zero normal, overlong vectors.
  frag_t directed_q[$] = '{
    '{Z, Z, P, Z, Z, P, Z, Z, P},
    '{Z, Z, M, Z, Z, M, Z, Z, M},
    '{P, P, P, P, P, P, P, P, P},
    '{M, M, M, M, M, M, M, M, M},
    '{Z, Z, P, P, Z, Z, M, Z, Z},
    '{Z, Z, P, Z, P, Z, Z, M, Z},
    '{Z, Z, P, Z, Z, P, Z, Z, M},
    '{Z, Z, Z, Z, Z, P, Z, Z, P},
    '{Z, Z, Z, Z, Z, Z, Z, Z, Z},
    '{Z, Z, P, Z, Z, Z, Z, Z, P},
    '{P, Z, Z, Z, Z, P, P, Z, Z},
    '{Z, Z, P, P, Z, Z, Z, Z, P},
    '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
      16'h7FFF, 16'h7FFF, 16'h7FFF},
    '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
      16'h8000, 16'h8000, 16'h8000},
    '{16'h5555, 16'hAAAA, 16'h3FFF, 16'hC001, 16'h0001, 16'hFFFF,
      16'h2AAA, 16'h1234, 16'hEDCB},
    '{Z, Z, P, 16'sd11585, Z, 16'sd11585, -16'sd11585, Z, 16'sd11585},
    '{Z, Z, P, Z, Z, 16'sd1, Z, Z, 16'sd1}
  };

  // Register settings per phase: reset values first, extremes included.
  logic [15:0] rough_set[6] = '{16'd65535, 16'd2949, 16'd0, 16'd65535, 16'd100, 16'd20000};
  logic [15:0] f0_set[6]    = '{16'd6554, 16'd0, 16'd65535, 16'd65535, 16'd30000, 16'd6554};

  initial begin
    frag_t fr;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Phase 0: reset register values, directed set, then random.
    foreach (directed_q[i]) send_frag(directed_q[i]);
    for (int i = 0; i < 200; i++) send_frag(rand_frag());

    for (int ph = 1; ph < 6; ph++) begin
      drain();  // every result in before touching a register
      if (ph == 5) begin
        write_reg(REG_ROUGHNESS, 16'($urandom_range(2949, 65535)));
        write_reg(REG_F0, 16'($urandom));
      end else begin
        write_reg(REG_ROUGHNESS, rough_set[ph]);
        write_reg(REG_F0, f0_set[ph]);
      end
      // A few directed items again under the new setting.
      for (int i = 0; i < 9; i++) send_frag(directed_q[i]);
      gaps_on   = (ph != 3);
      stalls_on = (ph != 4);
      for (int i = 0; i < 210; i++) begin
        // Long receiver hold-off with the sender still pushing: the pipe
        // and skid fill and frag.ready must drop.
        if (ph == 2 && i == 40) begin
          hold_req = 1'b1;
          gaps_on  = 1'b0;
        end
        send_frag(rand_frag());
      end
      gaps_on = 1'b1;
    end

    frag_ch.valid = 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (LATENCY + 20) @(negedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
